// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and the command beat type of the text console
// writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int unsigned COLUMNS_DEFAULT = 80;
   localparam int unsigned ROWS_DEFAULT    = 25;

   localparam int unsigned ADDR_W      = 15;
   localparam int unsigned NEXT_W      = 11;
   localparam int unsigned DIV_SHIFT   = 16;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned TAB_STEP    = 4;

   localparam logic [7:0] ATTR_RESET = 8'h07;

   localparam logic [2:0] OP_PUT_CHAR    = 3'd0;
   localparam logic [2:0] OP_FILL_SCREEN = 3'd1;
   localparam logic [2:0] OP_FILL_ROW    = 3'd2;
   localparam logic [2:0] OP_SCROLL_UP   = 3'd3;
   localparam logic [2:0] OP_READ_CELL   = 3'd4;

   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   localparam logic [2:0] ACT_NONE       = 3'd0;
   localparam logic [2:0] ACT_WRITE      = 3'd1;
   localparam logic [2:0] ACT_CLEAR_CHAR = 3'd2;
   localparam logic [2:0] ACT_READ       = 3'd3;
   localparam logic [2:0] ACT_FILL       = 3'd4;
   localparam logic [2:0] ACT_SCROLL     = 3'd5;

   typedef struct packed {
      logic [2:0]        act;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] last;
      logic [7:0]        chr;
      logic [NEXT_W-1:0] next_pos;
   } cmd_type;

endpackage

// ===== sv/tcw_queue.sv =====
// ----------------------------------------------------------------------------
// tcw_queue
// Short command queue between the classifier and the screen store engine.
// ----------------------------------------------------------------------------
module tcw_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  tcw_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output tcw_pkg::cmd_type pop_data
);

   localparam int unsigned DEPTH = tcw_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tcw_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[head_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

endmodule

// ===== sv/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front
// Accepts request beats, resolves the cell position, splits it into row and
// column and turns each request into one store command.
// ----------------------------------------------------------------------------
module tcw_front #(
   parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      hold,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_op,
   input  logic [7:0]                req_char_code,
   input  logic signed [11:0]        req_position,
   input  logic [10:0]               req_cursor_position,
   input  logic [4:0]                req_row_index,
   output logic                      cmd_valid,
   input  logic                      cmd_ready,
   output tcw_pkg::cmd_type          cmd_data
);

   localparam int unsigned CELLS   = COLUMNS * ROWS;
   localparam int unsigned AW      = tcw_pkg::ADDR_W;
   localparam int unsigned NW      = tcw_pkg::NEXT_W;
   localparam int unsigned RECIP_W = tcw_pkg::DIV_SHIFT - 2;
   localparam int unsigned PROD_W  = NW + RECIP_W;
   localparam int unsigned QC_W    = NW + 9;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((1 << tcw_pkg::DIV_SHIFT) / COLUMNS);

   logic          a_valid_ff, a_valid_in;
   logic [2:0]    a_op_ff;
   logic [7:0]    a_chr_ff;
   logic [NW-1:0] a_pos_ff;
   logic          a_pos_ok_ff;
   logic [NW-1:0] a_qest_ff;
   logic [4:0]    a_row_ff;

   logic              accept, push;
   logic              use_cursor;
   logic [NW-1:0]     pos;
   logic              pos_ok;
   logic [PROD_W-1:0] prod;
   logic [QC_W-1:0]   qc;
   logic [NW-1:0]     rem_raw, rem, quo, row_start;
   logic              rem_ge;
   logic [AW-1:0]     row_base;
   tcw_pkg::cmd_type  cmd;

   assign push      = a_valid_ff && cmd_ready;
   assign req_ready = !hold && (!a_valid_ff || cmd_ready);
   assign accept    = req_valid && req_ready;

   assign use_cursor = &req_position;
   assign pos        = use_cursor ? req_cursor_position : req_position[10:0];
   assign pos_ok     = (use_cursor || !req_position[11]) && (32'(pos) < CELLS);
   assign prod       = PROD_W'(pos) * PROD_W'(RECIP);

   assign a_valid_in = accept || (a_valid_ff && !push);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_op_ff     <= req_op;
         a_chr_ff    <= req_char_code;
         a_pos_ff    <= pos;
         a_pos_ok_ff <= pos_ok;
         a_qest_ff   <= NW'(prod >> tcw_pkg::DIV_SHIFT);
         a_row_ff    <= req_row_index;
      end
   end

   assign qc        = QC_W'(a_qest_ff) * QC_W'(COLUMNS);
   assign rem_raw   = NW'(QC_W'(a_pos_ff) - qc);
   assign rem_ge    = (32'(rem_raw) >= COLUMNS);
   assign rem       = rem_ge ? rem_raw - NW'(COLUMNS) : rem_raw;
   assign quo       = rem_ge ? a_qest_ff + 1'b1 : a_qest_ff;
   assign row_start = a_pos_ff - rem;
   assign row_base  = AW'(a_row_ff) * AW'(COLUMNS);

   always_comb begin
      cmd.act      = tcw_pkg::ACT_NONE;
      cmd.addr     = AW'(a_pos_ff);
      cmd.last     = AW'(CELLS - 1);
      cmd.chr      = a_chr_ff;
      cmd.next_pos = '0;
      case (a_op_ff)
         tcw_pkg::OP_PUT_CHAR: begin
            if (!a_pos_ok_ff) begin
               cmd.next_pos = NW'(CELLS - 1);
            end else begin
               case (a_chr_ff)
                  tcw_pkg::CH_CR: begin
                     cmd.next_pos = row_start;
                  end
                  tcw_pkg::CH_TAB: begin
                     cmd.next_pos = (32'(a_pos_ff) > CELLS - 5) ? NW'(CELLS - 1) :
                                    a_pos_ff + NW'(tcw_pkg::TAB_STEP);
                  end
                  tcw_pkg::CH_BS: begin
                     if (a_pos_ff != '0) begin
                        cmd.act      = tcw_pkg::ACT_CLEAR_CHAR;
                        cmd.addr     = AW'(a_pos_ff - 1'b1);
                        cmd.next_pos = a_pos_ff - 1'b1;
                     end
                  end
                  tcw_pkg::CH_NL: begin
                     if (32'(quo) == ROWS - 1) begin
                        cmd.act      = tcw_pkg::ACT_SCROLL;
                        cmd.next_pos = row_start;
                     end else begin
                        cmd.next_pos = row_start + NW'(COLUMNS);
                     end
                  end
                  default: begin
                     cmd.act      = tcw_pkg::ACT_WRITE;
                     cmd.next_pos = a_pos_ff + 1'b1;
                  end
               endcase
            end
         end
         tcw_pkg::OP_FILL_SCREEN: begin
            cmd.act  = tcw_pkg::ACT_FILL;
            cmd.addr = '0;
         end
         tcw_pkg::OP_FILL_ROW: begin
            if (32'(a_row_ff) < ROWS) begin
               cmd.act  = tcw_pkg::ACT_FILL;
               cmd.addr = row_base;
               cmd.last = row_base + AW'(COLUMNS - 1);
            end
         end
         tcw_pkg::OP_SCROLL_UP: begin
            cmd.act = tcw_pkg::ACT_SCROLL;
         end
         tcw_pkg::OP_READ_CELL: begin
            cmd.act  = tcw_pkg::ACT_READ;
            cmd.addr = a_pos_ok_ff ? AW'(a_pos_ff) : AW'(CELLS - 1);
         end
         default: begin
            cmd.act = tcw_pkg::ACT_NONE;
         end
      endcase
   end

   assign cmd_valid = a_valid_ff;
   assign cmd_data  = cmd;

endmodule

// ===== sv/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back
// Screen store engine: holds the character and attribute memories, carries
// out store commands and drives the response register.
// ----------------------------------------------------------------------------
module tcw_back #(
   parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [7:0]                 text_attribute,
   input  logic                       cmd_valid,
   output logic                       cmd_ready,
   input  tcw_pkg::cmd_type           cmd_data,
   output logic                       clear_busy,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [tcw_pkg::NEXT_W-1:0] rsp_next_position,
   output logic [7:0]                 rsp_cell_char,
   output logic [7:0]                 rsp_cell_attr
);

   localparam int unsigned CELLS  = COLUMNS * ROWS;
   localparam int unsigned CELL_W = $clog2(CELLS);
   localparam int unsigned NW     = tcw_pkg::NEXT_W;
   localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_FILL  = 3'd2;
   localparam logic [2:0] ST_COPY  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_TAIL  = 3'd5;
   localparam logic [2:0] ST_READ  = 3'd6;

   logic [7:0] char_mem [CELLS];
   logic [7:0] attr_mem [CELLS];

   logic [2:0]        state_ff, state_in;
   logic [CELL_W-1:0] ptr_ff, ptr_in;
   logic [CELL_W-1:0] last_ff, last_in;
   logic [7:0]        fchr_ff, fchr_in;
   logic [NW-1:0]     hold_ff, hold_in;
   logic              pipe_ff;
   logic [CELL_W-1:0] wr_addr_ff;
   logic [7:0]        rd_char_ff, rd_attr_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]     rsp_next_ff;
   logic [7:0]        rsp_char_ff, rsp_attr_ff;

   logic              rsp_free, pop, rsp_load;
   logic              we_char, we_attr;
   logic [CELL_W-1:0] waddr, raddr;
   logic [7:0]        wchar, wattr;
   logic [NW-1:0]     rsp_next_in;
   logic [7:0]        rsp_char_in, rsp_attr_in;

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign clear_busy = (state_ff == ST_CLEAR);
   assign cmd_ready  = pop;

   always_comb begin
      state_in    = state_ff;
      ptr_in      = ptr_ff;
      last_in     = last_ff;
      fchr_in     = fchr_ff;
      hold_in     = hold_ff;
      pop         = 1'b0;
      rsp_load    = 1'b0;
      rsp_next_in = hold_ff;
      rsp_char_in = '0;
      rsp_attr_in = '0;
      we_char     = 1'b0;
      we_attr     = 1'b0;
      waddr       = ptr_ff;
      wchar       = '0;
      wattr       = '0;
      raddr       = (state_ff == ST_COPY) ? ptr_ff : CELL_W'(cmd_data.addr);
      case (state_ff)
         ST_CLEAR: begin
            we_char = 1'b1;
            we_attr = 1'b1;
            if (ptr_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (cmd_valid && rsp_free) begin
               pop         = 1'b1;
               hold_in     = cmd_data.next_pos;
               rsp_next_in = cmd_data.next_pos;
               case (cmd_data.act)
                  tcw_pkg::ACT_WRITE: begin
                     we_char  = 1'b1;
                     we_attr  = 1'b1;
                     waddr    = CELL_W'(cmd_data.addr);
                     wchar    = cmd_data.chr;
                     wattr    = text_attribute;
                     rsp_load = 1'b1;
                  end
                  tcw_pkg::ACT_CLEAR_CHAR: begin
                     we_char  = 1'b1;
                     waddr    = CELL_W'(cmd_data.addr);
                     rsp_load = 1'b1;
                  end
                  tcw_pkg::ACT_READ: begin
                     state_in = ST_READ;
                  end
                  tcw_pkg::ACT_FILL: begin
                     ptr_in   = CELL_W'(cmd_data.addr);
                     last_in  = CELL_W'(cmd_data.last);
                     fchr_in  = cmd_data.chr;
                     state_in = ST_FILL;
                  end
                  tcw_pkg::ACT_SCROLL: begin
                     ptr_in   = CELL_W'(COLUMNS);
                     state_in = ST_COPY;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_FILL: begin
            we_char = 1'b1;
            we_attr = 1'b1;
            wchar   = fchr_ff;
            wattr   = text_attribute;
            if (ptr_ff == last_ff) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_COPY: begin
            we_char = pipe_ff;
            we_attr = pipe_ff;
            waddr   = wr_addr_ff;
            wchar   = rd_char_ff;
            wattr   = rd_attr_ff;
            if (ptr_ff == LAST_CELL) begin
               ptr_in   = CELL_W'(CELLS - COLUMNS);
               state_in = ST_DRAIN;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            we_char  = 1'b1;
            we_attr  = 1'b1;
            waddr    = wr_addr_ff;
            wchar    = rd_char_ff;
            wattr    = rd_attr_ff;
            state_in = ST_TAIL;
         end
         ST_TAIL: begin
            we_char = 1'b1;
            we_attr = 1'b1;
            wattr   = text_attribute;
            if (ptr_ff == LAST_CELL) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_READ: begin
            rsp_load    = 1'b1;
            rsp_char_in = rd_char_ff;
            rsp_attr_in = rd_attr_ff;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         pipe_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         pipe_ff      <= (state_ff == ST_COPY);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff    <= last_in;
      fchr_ff    <= fchr_in;
      hold_ff    <= hold_in;
      wr_addr_ff <= ptr_ff - CELL_W'(COLUMNS);
      if (rsp_load) begin
         rsp_next_ff <= rsp_next_in;
         rsp_char_ff <= rsp_char_in;
         rsp_attr_ff <= rsp_attr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we_char) begin
         char_mem[waddr] <= wchar;
      end
      if (we_attr) begin
         attr_mem[waddr] <= wattr;
      end
      rd_char_ff <= char_mem[raddr];
      rd_attr_ff <= attr_mem[raddr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_position = rsp_next_ff;
   assign rsp_cell_char     = rsp_char_ff;
   assign rsp_cell_attr     = rsp_attr_ff;

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE))
      else $error("command taken outside idle");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_load)
      else $error("response during clearing pass");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free)
      else $error("response register overwritten");

   a_drain_has_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> pipe_ff)
      else $error("scroll drain without pending copy");

endmodule

// ===== sv/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode screen store of ROWS x COLUMNS character and attribute cells.
// Throughput: one put/no-op beat per cycle while rsp_ready keeps the result
// register free; fills and scrolls walk the store through its single write
// port, one cell per cycle, and stall input.
// Reset: clearing pass over all CELLS cells with req_ready low.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [2:0]                 req_op,
   input  logic [7:0]                 req_char_code,
   input  logic signed [11:0]         req_position,
   input  logic [10:0]                req_cursor_position,
   input  logic [4:0]                 req_row_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [tcw_pkg::NEXT_W-1:0] rsp_next_position,
   output logic [7:0]                 rsp_cell_char,
   output logic [7:0]                 rsp_cell_attr,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [7:0]                 csr_text_attribute
);

   logic [7:0]       attr_ff, attr_in;
   logic             clear_busy;
   logic             f_valid, f_ready;
   tcw_pkg::cmd_type f_data;
   logic             q_valid, q_ready;
   tcw_pkg::cmd_type q_data;

   assign csr_ready = 1'b1;
   assign attr_in   = (csr_valid && csr_ready) ? csr_text_attribute : attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tcw_pkg::ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .hold                (clear_busy),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_char_code       (req_char_code),
      .req_position        (req_position),
      .req_cursor_position (req_cursor_position),
      .req_row_index       (req_row_index),
      .cmd_valid           (f_valid),
      .cmd_ready           (f_ready),
      .cmd_data            (f_data)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .text_attribute    (attr_ff),
      .cmd_valid         (q_valid),
      .cmd_ready         (q_ready),
      .cmd_data          (q_data),
      .clear_busy        (clear_busy),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_position (rsp_next_position),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_attr     (rsp_cell_attr)
   );

endmodule

// ===== tb/tcw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Watches the command, result and attribute channels of the text console
// writer. Keeps a shadow copy of the screen store and the attribute register.
// Predicts the reply to every accepted command beat and compares each result
// beat, field by field, with the oldest reply still due.
// ----------------------------------------------------------------------------
module tcw_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_op,
   input  logic [7:0]         req_char_code,
   input  logic signed [11:0] req_position,
   input  logic [10:0]        req_cursor_position,
   input  logic [4:0]         req_row_index,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [10:0]        rsp_next_position,
   input  logic [7:0]         rsp_cell_char,
   input  logic [7:0]         rsp_cell_attr,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [7:0]         csr_text_attribute,
   output int                 fail_count,
   output int                 pending_count
);

   localparam int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT;
   localparam int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT;
   localparam int unsigned CELLS   = COLUMNS * ROWS;

   typedef struct packed {
      logic [10:0] next_pos;
      logic [7:0]  chr;
      logic [7:0]  attr;
   } cell_reply_type;

   logic [7:0]     shadow_chars [CELLS];
   logic [7:0]     shadow_attrs [CELLS];
   logic [7:0]     shadow_attr_reg;
   cell_reply_type replies_due [$];
   int             mismatches = 0;

   assign fail_count = mismatches;

   function automatic logic resolve_cell(input logic [11:0] pos, input logic [10:0] cur,
                                         output int unsigned idx);
      int unsigned p;
      if (pos == 12'hFFF) begin
         p = cur;
      end else if (pos[11]) begin
         idx = 0;
         return 1'b0;
      end else begin
         p = pos;
      end
      idx = p;
      return p < CELLS;
   endfunction

   function automatic void scroll_shadow();
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
         shadow_chars[i] = shadow_chars[i + COLUMNS];
         shadow_attrs[i] = shadow_attrs[i + COLUMNS];
      end
      for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
         shadow_chars[i] = 8'h00;
         shadow_attrs[i] = shadow_attr_reg;
      end
   endfunction

   function automatic logic [10:0] put_shadow(input logic [7:0] c, input logic [11:0] pos,
                                              input logic [10:0] cur);
      int unsigned off;
      if (!resolve_cell(pos, cur, off))
         return 11'(CELLS - 1);
      case (c)
         tcw_pkg::CH_CR: return 11'(off - off % COLUMNS);
         tcw_pkg::CH_TAB: return (off > CELLS - 5) ? 11'(CELLS - 1) :
                                 11'(off + tcw_pkg::TAB_STEP);
         tcw_pkg::CH_BS: begin
            if (off > 0) begin
               shadow_chars[off - 1] = 8'h00;
               return 11'(off - 1);
            end
            return 11'(off);
         end
         tcw_pkg::CH_NL: begin
            if (off / COLUMNS == ROWS - 1) begin
               scroll_shadow();
               return 11'(off - off % COLUMNS);
            end
            return 11'(off + COLUMNS - off % COLUMNS);
         end
         default: begin
            shadow_chars[off] = c;
            shadow_attrs[off] = shadow_attr_reg;
            return 11'(off + 1);
         end
      endcase
   endfunction

   function automatic cell_reply_type apply_console_cmd(input logic [2:0] op,
                                                        input logic [7:0] c,
                                                        input logic [11:0] pos,
                                                        input logic [10:0] cur,
                                                        input logic [4:0] row);
      cell_reply_type r;
      int unsigned    idx;
      r = '0;
      case (op)
         tcw_pkg::OP_PUT_CHAR: r.next_pos = put_shadow(c, pos, cur);
         tcw_pkg::OP_FILL_SCREEN: begin
            for (int i = 0; i < CELLS; i++) begin
               shadow_chars[i] = c;
               shadow_attrs[i] = shadow_attr_reg;
            end
         end
         tcw_pkg::OP_FILL_ROW: begin
            if (row < ROWS) begin
               for (int i = row * COLUMNS; i < (row + 1) * COLUMNS; i++) begin
                  shadow_chars[i] = c;
                  shadow_attrs[i] = shadow_attr_reg;
               end
            end
         end
         tcw_pkg::OP_SCROLL_UP: scroll_shadow();
         tcw_pkg::OP_READ_CELL: begin
            if (!resolve_cell(pos, cur, idx))
               idx = CELLS - 1;
            r.chr  = shadow_chars[idx];
            r.attr = shadow_attrs[idx];
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      cell_reply_type want;
      if (reset) begin
         for (int i = 0; i < CELLS; i++) begin
            shadow_chars[i] = 8'h00;
            shadow_attrs[i] = 8'h00;
         end
         shadow_attr_reg = tcw_pkg::ATTR_RESET;
         replies_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               $error("result beat with no command outstanding");
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_next_position !== want.next_pos) begin
                  $error("next_position: expected %0d, actual %0d",
                         want.next_pos, rsp_next_position);
                  mismatches++;
               end
               if (rsp_cell_char !== want.chr) begin
                  $error("cell_char: expected %0d, actual %0d", want.chr, rsp_cell_char);
                  mismatches++;
               end
               if (rsp_cell_attr !== want.attr) begin
                  $error("cell_attr: expected %0d, actual %0d", want.attr, rsp_cell_attr);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready)
            shadow_attr_reg = csr_text_attribute;
         if (req_valid && req_ready)
            replies_due.push_back(apply_console_cmd(req_op, req_char_code, req_position,
                                                    req_cursor_position, req_row_index));
      end
      pending_count <= replies_due.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the text console writer with directed commands covering control
// codes, screen edges, cursor-relative and out-of-range positions, fills,
// scrolls and unused opcodes, then with random command streams under three
// back-pressure profiles and several attribute settings. The checker beside
// the block scores every result beat.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned CELLS            = tcw_pkg::COLUMNS_DEFAULT *
                                              tcw_pkg::ROWS_DEFAULT;
   localparam int          RANDOM_PER_PHASE = 360;
   localparam logic [2:0]  OP_UNUSED_LO     = 3'd5;
   localparam logic [2:0]  OP_UNUSED_HI     = 3'd7;
   localparam logic [11:0] POS_CURSOR       = 12'hFFF;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [2:0]                 req_op = '0;
   logic [7:0]                 req_char_code = '0;
   logic signed [11:0]         req_position = '0;
   logic [10:0]                req_cursor_position = '0;
   logic [4:0]                 req_row_index = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [tcw_pkg::NEXT_W-1:0] rsp_next_position;
   logic [7:0]                 rsp_cell_char;
   logic [7:0]                 rsp_cell_attr;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [7:0]                 csr_text_attribute = '0;

   int send_idle_pct = 16;
   int recv_idle_pct = 87;
   int hot_base = 0;
   int fail_count;
   int pending_count;

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   text_console_writer u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_char_code       (req_char_code),
      .req_position        (req_position),
      .req_cursor_position (req_cursor_position),
      .req_row_index       (req_row_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_next_position   (rsp_next_position),
      .rsp_cell_char       (rsp_cell_char),
      .rsp_cell_attr       (rsp_cell_attr),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_text_attribute  (csr_text_attribute)
   );

   tcw_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_char_code       (req_char_code),
      .req_position        (req_position),
      .req_cursor_position (req_cursor_position),
      .req_row_index       (req_row_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_next_position   (rsp_next_position),
      .rsp_cell_char       (rsp_cell_char),
      .rsp_cell_attr       (rsp_cell_attr),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_text_attribute  (csr_text_attribute),
      .fail_count          (fail_count),
      .pending_count       (pending_count)
   );

   task automatic send_cmd(input logic [2:0] op, input logic [7:0] ch,
                           input logic [11:0] pos, input logic [10:0] cur,
                           input logic [4:0] row);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_op              <= op;
      req_char_code       <= ch;
      req_position        <= pos;
      req_cursor_position <= cur;
      req_row_index       <= row;
      req_valid           <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results(input int settle_cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (settle_cycles) @(negedge clock);
   endtask

   task automatic write_attr(input logic [7:0] value);
      drain_results(16);
      csr_text_attribute <= value;
      csr_valid          <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random();
      int unsigned sel;
      int unsigned pick;
      logic [2:0]  op;
      logic [7:0]  ch;
      logic [11:0] pos;
      logic [10:0] cur;
      logic [4:0]  row;
      sel = $urandom_range(99);
      if (sel < 55)      op = tcw_pkg::OP_PUT_CHAR;
      else if (sel < 80) op = tcw_pkg::OP_READ_CELL;
      else if (sel < 90) op = tcw_pkg::OP_FILL_ROW;
      else if (sel < 92) op = tcw_pkg::OP_FILL_SCREEN;
      else if (sel < 94) op = tcw_pkg::OP_SCROLL_UP;
      else if (sel < 97) op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      else               op = tcw_pkg::OP_PUT_CHAR;
      // move the hot window now and then, sometimes onto the last two rows
      if ($urandom_range(99) < 3)
         hot_base = $urandom_range(tcw_pkg::ROWS_DEFAULT - 2) * tcw_pkg::COLUMNS_DEFAULT;
      if ($urandom_range(99) < 40) begin
         case ($urandom_range(3))
            0:       ch = tcw_pkg::CH_CR;
            1:       ch = tcw_pkg::CH_TAB;
            2:       ch = tcw_pkg::CH_BS;
            default: ch = tcw_pkg::CH_NL;
         endcase
      end else begin
         ch = 8'($urandom_range(255));
      end
      cur  = 11'($urandom_range(2047));
      pick = $urandom_range(99);
      if (pick < 45) begin
         pos = 12'(hot_base + $urandom_range(2 * tcw_pkg::COLUMNS_DEFAULT - 1));
      end else if (pick < 60) begin
         pos = POS_CURSOR;
         if ($urandom_range(99) < 70)
            cur = 11'(hot_base + $urandom_range(2 * tcw_pkg::COLUMNS_DEFAULT - 1));
      end else if (pick < 70) begin
         if ($urandom_range(1) == 0) pos = 12'($urandom_range(2047, CELLS));
         else                        pos = 12'($urandom_range(4095, 2048));
      end else begin
         pos = 12'($urandom_range(CELLS - 1));
      end
      row = 5'($urandom_range(31));
      send_cmd(op, ch, pos, cur, row);
   endtask

   initial begin
      #100ms;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      send_cmd(tcw_pkg::OP_READ_CELL,   8'h00,           12'd0,      11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_PUT_CHAR,    8'h41,           12'd0,      11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_PUT_CHAR,    8'hFF,           12'd1999,   11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_READ_CELL,   8'h00,           12'd1999,   11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_PUT_CHAR,    tcw_pkg::CH_CR,  12'd85,     11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_PUT_CHAR,    tcw_pkg::CH_TAB, 12'd10,     11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_PUT_CHAR,    tcw_pkg::CH_TAB, 12'd1996,   11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_PUT_CHAR,    tcw_pkg::CH_BS,  12'd1,      11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_PUT_CHAR,    tcw_pkg::CH_BS,  12'd0,      11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_READ_CELL,   8'h00,           12'd0,      11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_PUT_CHAR,    tcw_pkg::CH_NL,  12'd100,    11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_PUT_CHAR,    tcw_pkg::CH_NL,  12'd1990,   11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_READ_CELL,   8'h00,           12'd1919,   11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_PUT_CHAR,    8'h5A,           POS_CURSOR, 11'd5,    5'd0);
      send_cmd(tcw_pkg::OP_PUT_CHAR,    8'h5A,           POS_CURSOR, 11'd2047, 5'd0);
      send_cmd(tcw_pkg::OP_PUT_CHAR,    8'h33,           12'd2000,   11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_PUT_CHAR,    8'h33,           12'h800,    11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_READ_CELL,   8'h00,           POS_CURSOR, 11'd5,    5'd0);
      send_cmd(tcw_pkg::OP_READ_CELL,   8'h00,           12'd2047,   11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_FILL_SCREEN, 8'h20,           12'd0,      11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_FILL_ROW,    8'h2A,           12'd0,      11'd0,    5'd24);
      send_cmd(tcw_pkg::OP_FILL_ROW,    8'h2B,           12'd0,      11'd0,    5'd25);
      send_cmd(tcw_pkg::OP_SCROLL_UP,   8'h00,           12'd0,      11'd0,    5'd0);
      send_cmd(tcw_pkg::OP_READ_CELL,   8'h00,           12'd1840,   11'd0,    5'd0);
      send_cmd(OP_UNUSED_HI,            8'hFF,           12'hFFF,    11'h7FF,  5'h1F);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               write_attr(8'h00);
            end
            1: begin
               send_idle_pct = 87;
               recv_idle_pct = 16;
               write_attr(8'hFF);
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               write_attr(8'($urandom_range(255)));
            end
         endcase
         repeat (RANDOM_PER_PHASE) begin
            if ($urandom_range(199) == 0)
               drain_results(0);
            send_random();
         end
      end

      drain_results(CELLS + 10);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
